// File: design/tsrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrt_pkg
// Shared types, constants and a helper of the segment reassembly table.
// ----------------------------------------------------------------------------
package tsrt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
   localparam int TOT_W       = 16 + CNT_W;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_READ   = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [31:0] seq_num;
      logic [15:0] seg_length;
      logic [7:0]  seg_handle;
   } req_type;

   typedef struct packed {
      logic [15:0] inserted_bytes;
      logic        status;
      logic        found;
      logic [7:0]  out_handle;
      logic [15:0] byte_offset;
      logic [15:0] byte_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic cov_step;
      logic search;
      logic save_before;
      logic walk_clear;
      logic dup_update;
      logic ins_shift;
      logic ins_finish;
      logic ins_refuse;
      logic rd_miss;
      logic rd_start;
      logic rd_step;
      logic rd_flush;
      logic rd_shift;
      logic push_result;
   } cmd_type;

   typedef struct packed {
      logic walk_end;
      logic hit;
      logic full;
      logic dup;
      logic rd_done;
      logic rd_piece;
      logic pend;
      logic slot_free;
      logic idx_zero;
   } sts_type;

   function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

endpackage

// File: design/tsrt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrt_ctrl
// Sequencer that steps the datapath through insert and read operations.
// ----------------------------------------------------------------------------
module tsrt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_mode,
   output logic              req_stall,
   input  tsrt_pkg::sts_type sts,
   output tsrt_pkg::cmd_type cmd
);
   import tsrt_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_INS_COV1 = 10'b0000000010,
      ST_DECIDE   = 10'b0000000100,
      ST_INS_COV2 = 10'b0000001000,
      ST_PUSH     = 10'b0000010000,
      ST_RD_CHECK = 10'b0000100000,
      ST_RD_WALK  = 10'b0001000000,
      ST_RD_FLUSH = 10'b0010000000,
      ST_RD_SHIFT = 10'b0100000000,
      ST_INS_END  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_mode == MODE_READ) ? ST_RD_CHECK : ST_INS_COV1;
            end
         end
         ST_INS_COV1: begin
            if (sts.walk_end) begin
               cmd.save_before = 1'b1;
               state_in        = ST_DECIDE;
            end else begin
               cmd.cov_step = 1'b1;
               cmd.search   = 1'b1;
            end
         end
         ST_DECIDE: begin
            if (sts.dup) begin
               cmd.dup_update = 1'b1;
               cmd.walk_clear = 1'b1;
               state_in       = ST_INS_COV2;
            end else if (sts.full) begin
               cmd.ins_refuse = 1'b1;
               state_in       = ST_PUSH;
            end else begin
               cmd.ins_shift  = 1'b1;
               cmd.walk_clear = 1'b1;
               state_in       = ST_INS_COV2;
            end
         end
         ST_INS_COV2: begin
            if (sts.walk_end) begin
               state_in = ST_INS_END;
            end else begin
               cmd.cov_step = 1'b1;
            end
         end
         ST_INS_END: begin
            cmd.ins_finish = 1'b1;
            state_in       = ST_PUSH;
         end
         ST_PUSH: begin
            if (sts.slot_free) begin
               cmd.push_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_RD_CHECK: begin
            if (sts.hit) begin
               cmd.rd_start = 1'b1;
               state_in     = ST_RD_WALK;
            end else begin
               cmd.rd_miss = 1'b1;
               state_in    = ST_PUSH;
            end
         end
         ST_RD_WALK: begin
            if (sts.rd_done) begin
               state_in = ST_RD_FLUSH;
            end else if (!(sts.rd_piece && sts.pend && !sts.slot_free)) begin
               cmd.rd_step = 1'b1;
            end
         end
         ST_RD_FLUSH: begin
            if (sts.slot_free) begin
               cmd.rd_flush = 1'b1;
               state_in     = ST_RD_SHIFT;
            end
         end
         ST_RD_SHIFT: begin
            if (sts.idx_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.rd_shift = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/tsrt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrt_dp
// Descriptor table, coverage walker, read walker and result register.
// ----------------------------------------------------------------------------
module tsrt_dp (
   input  logic              clock,
   input  logic              reset,
   input  tsrt_pkg::req_type req_data,
   input  tsrt_pkg::cmd_type cmd,
   output tsrt_pkg::sts_type sts,
   output tsrt_pkg::rsp_type rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_stall
);
   import tsrt_pkg::*;

   logic [31:0] seq_mem [TABLE_DEPTH];
   logic [15:0] len_mem [TABLE_DEPTH];
   logic [7:0]  hdl_mem [TABLE_DEPTH];

   req_type           req_ff;
   logic [CNT_W-1:0]  count_ff, idx_ff, pos_ff;
   logic              found_ff, dup_ff;
   logic [31:0]       cursor_ff;
   logic [TOT_W-1:0]  total_ff, before_ff;
   logic [NRES_W-1:0] n_ff;
   logic              pend_ff;
   logic [7:0]        pend_hdl_ff;
   logic [15:0]       pend_off_ff, pend_cnt_ff;
   logic [15:0]       res_bytes_ff;
   logic              res_status_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic [31:0]      rd_seq;
   logic [15:0]      rd_len;
   logic [7:0]       rd_hdl;
   logic             first, full, slot_free;
   logic [31:0]      cov_cur, cov_base, cov_diff;
   logic [TOT_W-1:0] cov_tot, gdiff;
   logic [15:0]      cov_add, growth;
   logic [31:0]      rw_diff;
   logic             rw_piece, rw_gap;
   logic [15:0]      rw_off, rw_cnt;
   logic [CNT_W-1:0] pos_final, rm_pos;
   logic             remove_en;
   rsp_type          piece_rsp;
   rsp_type          done_rsp;

   assign rd_seq    = seq_mem[idx_ff[IDX_W-1:0]];
   assign rd_len    = len_mem[idx_ff[IDX_W-1:0]];
   assign rd_hdl    = hdl_mem[idx_ff[IDX_W-1:0]];
   assign first     = (idx_ff == '0);
   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pos_final = found_ff ? pos_ff : idx_ff;

   always_comb begin
      cov_cur  = first ? rd_seq : cursor_ff;
      cov_tot  = first ? '0 : total_ff;
      cov_diff = cov_cur - rd_seq;
      cov_base = cov_cur;
      if (cov_diff == '0) begin
         cov_add = rd_len;
      end else if (cov_diff < {16'b0, rd_len}) begin
         cov_add = rd_len - cov_diff[15:0];
      end else if (seq_before(rd_seq, cov_cur)) begin
         cov_add = '0;
      end else begin
         cov_add  = rd_len;
         cov_base = rd_seq;
      end
   end

   always_comb begin
      gdiff = (cov_tot > before_ff) ? (cov_tot - before_ff) : '0;
      if (gdiff > TOT_W'(16'hFFFF)) begin
         growth = 16'hFFFF;
      end else begin
         growth = gdiff[15:0];
      end
   end

   assign rw_diff  = cursor_ff - rd_seq;
   assign rw_piece = (rw_diff == '0) || (rw_diff < {16'b0, rd_len});
   assign rw_off   = rw_diff[15:0];
   assign rw_cnt   = rd_len - rw_off;
   assign rw_gap   = !rw_piece && !seq_before(rd_seq, cursor_ff);

   assign remove_en = cmd.rd_shift || (cmd.ins_finish && !dup_ff && (growth == '0));
   assign rm_pos    = cmd.rd_shift ? '0 : pos_ff;

   always_comb begin
      piece_rsp                = '0;
      piece_rsp.inserted_bytes = '0;
      piece_rsp.status         = STATUS_OK;
      piece_rsp.found          = 1'b1;
      piece_rsp.out_handle     = pend_hdl_ff;
      piece_rsp.byte_offset    = pend_off_ff;
      piece_rsp.byte_count     = pend_cnt_ff;
      piece_rsp.last           = cmd.rd_flush;
   end

   always_comb begin
      done_rsp                = '0;
      done_rsp.inserted_bytes = res_bytes_ff;
      done_rsp.status         = res_status_ff;
      done_rsp.last           = 1'b1;
   end

   always_comb begin
      sts           = '0;
      sts.walk_end  = (idx_ff == count_ff);
      sts.hit       = (count_ff != '0) && (rd_seq == req_ff.seq_num);
      sts.full      = full;
      sts.dup       = dup_ff;
      sts.rd_done   = (idx_ff == count_ff) || (n_ff == NRES_W'(MAX_RESULTS)) || rw_gap;
      sts.rd_piece  = rw_piece;
      sts.pend      = pend_ff;
      sts.slot_free = slot_free;
      sts.idx_zero  = (idx_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.dup_update && (req_ff.seg_length > rd_len)) begin
         len_mem[idx_ff[IDX_W-1:0]] <= req_ff.seg_length;
         hdl_mem[idx_ff[IDX_W-1:0]] <= req_ff.seg_handle;
      end
      if (cmd.ins_shift) begin
         for (int i = 1; i < TABLE_DEPTH; i++) begin
            if (CNT_W'(i) > pos_ff) begin
               seq_mem[i] <= seq_mem[i-1];
               len_mem[i] <= len_mem[i-1];
               hdl_mem[i] <= hdl_mem[i-1];
            end
         end
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (CNT_W'(i) == pos_ff) begin
               seq_mem[i] <= req_ff.seq_num;
               len_mem[i] <= req_ff.seg_length;
               hdl_mem[i] <= req_ff.seg_handle;
            end
         end
      end
      if (remove_en) begin
         for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
            if (CNT_W'(i) >= rm_pos) begin
               seq_mem[i] <= seq_mem[i+1];
               len_mem[i] <= len_mem[i+1];
               hdl_mem[i] <= hdl_mem[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.cov_step) begin
         cursor_ff <= cov_base + {16'b0, cov_add};
         total_ff  <= cov_tot + TOT_W'(cov_add);
      end
      if (cmd.rd_start) begin
         cursor_ff <= req_ff.seq_num;
      end
      if (cmd.rd_step && rw_piece) begin
         cursor_ff   <= cursor_ff + {16'b0, rw_cnt};
         pend_hdl_ff <= rd_hdl;
         pend_off_ff <= rw_off;
         pend_cnt_ff <= rw_cnt;
      end
      if (cmd.save_before) begin
         before_ff <= cov_tot;
         pos_ff    <= pos_final;
      end
      if (cmd.cov_step && cmd.search && !found_ff && !seq_before(rd_seq, req_ff.seq_num)) begin
         pos_ff <= idx_ff;
         dup_ff <= (rd_seq == req_ff.seq_num);
      end
      if (cmd.save_before) begin
         dup_ff <= found_ff && dup_ff;
      end
      if (cmd.ins_finish) begin
         res_bytes_ff  <= growth;
         res_status_ff <= STATUS_OK;
      end
      if (cmd.ins_refuse) begin
         res_bytes_ff  <= '0;
         res_status_ff <= STATUS_FULL;
      end
      if (cmd.rd_miss) begin
         res_bytes_ff  <= '0;
         res_status_ff <= STATUS_OK;
      end
      if (cmd.push_result) begin
         rsp_ff <= done_rsp;
      end else if ((cmd.rd_step && rw_piece && pend_ff) || cmd.rd_flush) begin
         rsp_ff <= piece_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         n_ff         <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture || cmd.walk_clear) begin
            idx_ff <= '0;
         end else if (cmd.cov_step || cmd.rd_step) begin
            idx_ff <= idx_ff + 1'b1;
         end else if (cmd.save_before) begin
            idx_ff <= pos_final;
         end else if (cmd.rd_shift) begin
            idx_ff <= idx_ff - 1'b1;
         end
         if (cmd.capture) begin
            found_ff <= 1'b0;
         end else if (cmd.cov_step && cmd.search && !seq_before(rd_seq, req_ff.seq_num)) begin
            found_ff <= 1'b1;
         end
         if (cmd.ins_shift) begin
            count_ff <= count_ff + 1'b1;
         end else if (remove_en) begin
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.rd_start) begin
            n_ff    <= '0;
            pend_ff <= 1'b0;
         end else if (cmd.rd_step && rw_piece) begin
            n_ff    <= n_ff + 1'b1;
            pend_ff <= 1'b1;
         end else if (cmd.rd_flush) begin
            pend_ff <= 1'b0;
         end
         if (cmd.push_result || cmd.rd_flush || (cmd.rd_step && rw_piece && pend_ff)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   a_no_insert_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_shift |-> !full)
      else $error("insert shift issued on a full table");

   a_flush_has_piece: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_flush |-> pend_ff)
      else $error("read flush without a pending piece");

   a_shift_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_shift |-> (count_ff != '0))
      else $error("read removal on an empty table");

endmodule

// File: design/tcp_segment_reassembly_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_segment_reassembly_table
// Sorted table of segment descriptors with insert and in-order read.
// ----------------------------------------------------------------------------
// An insert walks the stored entries for coverage, reading one entry per
// cycle, and, unless it is refused, walks them again after the update or
// shift. A read walks the entries to build its pieces, flushes the last piece
// and then removes the walked entries by a shift; a miss goes straight to its
// response. One request is processed at a time, the result register lets the
// next one in while a result waits. Reset empties the table.
module tcp_segment_reassembly_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tsrt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tsrt_pkg::rsp_type rsp_data
);
   import tsrt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tsrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tsrt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

endmodule

// File: sim/tb_tcp_segment_reassembly_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_segment_reassembly_table
// Drives insert and read requests into the reassembly table and checks every
// response against a behavioral model of the sorted descriptor table.
// ----------------------------------------------------------------------------
module tb_tcp_segment_reassembly_table;
   import tsrt_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   tcp_segment_reassembly_table u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   logic [31:0] tbl_seq [TABLE_DEPTH];
   logic [15:0] tbl_len [TABLE_DEPTH];
   logic [7:0]  tbl_hdl [TABLE_DEPTH];
   int          tbl_cnt;
   rsp_type     pending_rsp[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          hold_off;
   int          hold_reqs = 0;
   int          hold_seen;
   int          burst_left;
   bit          stall_mode;
   logic [31:0] base_seq;

   function automatic logic seq_precedes(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   function automatic longint coverage();
      longint      total;
      logic [31:0] cur;
      logic [31:0] diff;
      logic [31:0] add;
      total = 0;
      if (tbl_cnt == 0) return 0;
      cur = tbl_seq[0];
      for (int i = 0; i < tbl_cnt; i++) begin
         diff = cur - tbl_seq[i];
         if (diff == 0) add = tbl_len[i];
         else if (diff < tbl_len[i]) add = tbl_len[i] - diff;
         else if (seq_precedes(tbl_seq[i], cur)) add = 0;
         else begin
            add = tbl_len[i];
            cur = tbl_seq[i];
         end
         cur += add;
         total += add;
      end
      return total;
   endfunction

   function automatic rsp_type blank_rsp();
      rsp_type r;
      r = '0;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void predict_insert(logic [31:0] s, logic [15:0] l, logic [7:0] h);
      longint  was;
      longint  grow;
      int      pos;
      rsp_type r;
      r = blank_rsp();
      was = coverage();
      pos = 0;
      while (pos < tbl_cnt && seq_precedes(tbl_seq[pos], s)) pos++;
      if (pos < tbl_cnt && tbl_seq[pos] == s) begin
         if (tbl_len[pos] < l) begin
            tbl_len[pos] = l;
            tbl_hdl[pos] = h;
         end
         grow = coverage() - was;
      end else if (tbl_cnt >= TABLE_DEPTH) begin
         r.status = STATUS_FULL;
         grow = 0;
      end else begin
         for (int i = tbl_cnt; i > pos; i--) begin
            tbl_seq[i] = tbl_seq[i-1];
            tbl_len[i] = tbl_len[i-1];
            tbl_hdl[i] = tbl_hdl[i-1];
         end
         tbl_seq[pos] = s;
         tbl_len[pos] = l;
         tbl_hdl[pos] = h;
         tbl_cnt++;
         grow = coverage() - was;
         if (grow <= 0) begin
            for (int i = pos; i + 1 < tbl_cnt; i++) begin
               tbl_seq[i] = tbl_seq[i+1];
               tbl_len[i] = tbl_len[i+1];
               tbl_hdl[i] = tbl_hdl[i+1];
            end
            tbl_cnt--;
         end
      end
      if (grow < 0) grow = 0;
      if (grow > 65535) grow = 65535;
      r.inserted_bytes = grow[15:0];
      pending_rsp.push_back(r);
   endfunction

   function automatic void predict_read(logic [31:0] s);
      logic [31:0] cur;
      logic [31:0] diff;
      int          walked;
      int          n;
      rsp_type     r;
      if (tbl_cnt == 0 || tbl_seq[0] != s) begin
         pending_rsp.push_back(blank_rsp());
         return;
      end
      cur = s;
      walked = 0;
      n = 0;
      while (walked < tbl_cnt && n < MAX_RESULTS) begin
         diff = cur - tbl_seq[walked];
         r = '0;
         r.found = 1'b1;
         r.out_handle = tbl_hdl[walked];
         if (diff == 0) begin
            r.byte_count = tbl_len[walked];
            pending_rsp.push_back(r);
            n++;
            cur += tbl_len[walked];
         end else if (diff < tbl_len[walked]) begin
            r.byte_offset = diff[15:0];
            r.byte_count = tbl_len[walked] - diff[15:0];
            pending_rsp.push_back(r);
            n++;
            cur += tbl_len[walked] - diff;
         end else if (!seq_precedes(tbl_seq[walked], cur)) begin
            break;
         end
         walked++;
      end
      for (int i = 0; walked + i < tbl_cnt; i++) begin
         tbl_seq[i] = tbl_seq[walked+i];
         tbl_len[i] = tbl_len[walked+i];
         tbl_hdl[i] = tbl_hdl[walked+i];
      end
      tbl_cnt -= walked;
      r = pending_rsp.pop_back();
      r.last = 1'b1;
      pending_rsp.push_back(r);
   endfunction

   task automatic send_request(logic m, logic [31:0] s, logic [15:0] l, logic [7:0] h);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= '{mode: m, seq_num: s, seg_length: l, seg_handle: h};
      do @(posedge clock); while (req_stall);
      if (m == MODE_INSERT) predict_insert(s, l, h);
      else predict_read(s);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(MODE_READ, 32'h0, 16'h0, 8'h0);
      send_request(MODE_INSERT, 32'hFFFF_FFF0, 16'h0, 8'hFF);
      send_request(MODE_INSERT, 32'hFFFF_FFF0, 16'h20, 8'h01);
      send_request(MODE_INSERT, 32'h0000_0010, 16'hFFFF, 8'h02);
      send_request(MODE_INSERT, 32'hFFFF_FFF0, 16'h10, 8'h03);
      send_request(MODE_INSERT, 32'hFFFF_FFF0, 16'h40, 8'h04);
      send_request(MODE_INSERT, 32'hFFFF_FFF8, 16'h4, 8'h05);
      send_request(MODE_INSERT, 32'h0001_0020, 16'h8, 8'h06);
      send_request(MODE_INSERT, 32'h8000_0000, 16'hFFFF, 8'hAA);
      send_request(MODE_READ, 32'hFFFF_FFF1, 16'hFFFF, 8'hFF);
      send_request(MODE_READ, 32'hFFFF_FFF0, 16'h0, 8'h0);
      send_request(MODE_READ, 32'h8000_0000, 16'h0, 8'h0);
      for (int i = 0; i < 17; i++)
         send_request(MODE_INSERT, 32'h100 + 32'(i) * 32'h20, 16'h10, 8'(i));
      send_request(MODE_READ, 32'h100, 16'h0, 8'h0);
      wait_drained();
   endtask

   task automatic test_random_streams(int count);
      logic [31:0] s;
      logic [15:0] l;
      int          k;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 99);
         if (k < 12) begin
            send_request(MODE_READ, (k < 2) ? $urandom : base_seq, 16'($urandom),
                         8'($urandom));
            if (tbl_cnt == 0) base_seq = $urandom;
         end else if (k < 17) begin
            send_request(MODE_INSERT, $urandom, 16'($urandom), 8'($urandom));
         end else begin
            s = base_seq + $urandom_range(0, 400);
            l = (k < 20) ? 16'($urandom) : 16'($urandom_range(0, 80));
            send_request(MODE_INSERT, s, l, 8'($urandom));
         end
         if (tbl_cnt > 0 && $urandom_range(0, 3) == 0) base_seq = tbl_seq[0];
      end
   endtask

   task automatic test_backpressure();
      hold_reqs++;
      for (int i = 0; i < 20; i++)
         send_request(MODE_INSERT, base_seq + 32'(i) * 7, 16'($urandom_range(1, 9)),
                      8'($urandom));
      send_request(MODE_READ, tbl_cnt > 0 ? tbl_seq[0] : base_seq, 16'h0, 8'h0);
      wait_drained();
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("tcp_segment_reassembly_table verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_off   <= 0;
         hold_seen  <= 0;
         stall_mode <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
         hold_seen <= hold_reqs;
         hold_off  <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
         rsp_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.inserted_bytes !== e.inserted_bytes || rsp_data.status !== e.status
                || rsp_data.found !== e.found || rsp_data.out_handle !== e.out_handle
                || rsp_data.byte_offset !== e.byte_offset
                || rsp_data.byte_count !== e.byte_count || rsp_data.last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected %h actual %h", e, rsp_data);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      tbl_cnt = 0;
      burst_left = 0;
      base_seq = 32'hFFFF_FF00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_streams(200);
      test_backpressure();
      test_random_streams(220);
      wait_drained();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("tcp_segment_reassembly_table verification clean");
      else
         $display("tcp_segment_reassembly_table verification failed");
      $finish;
   end

endmodule

// File: filelist.f
design/tsrt_pkg.sv
design/tsrt_ctrl.sv
design/tsrt_dp.sv
design/tcp_segment_reassembly_table.sv
sim/tb_tcp_segment_reassembly_table.sv
